[sv/lhp_pkg.sv]
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared types and constants of the latency histogram percentile monitor.
// ----------------------------------------------------------------------------
package lhp_pkg;

    localparam int BINS      = 4096;
    localparam int BIN_W     = $clog2(BINS);
    localparam int GOALS     = 8;
    localparam int GOAL_W    = 3;
    localparam int BUCKET_US = 10;
    localparam int PERMILLE  = 1000;

    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] latency_us;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  goal_index;
        logic [11:0] bucket_index;
        logic [31:0] sample_count;
        logic [30:0] avg_latency;
        logic [31:0] min_latency;
        logic [30:0] max_latency;
        logic        last;
    } out_item_t;

    // Classified command passed from front to back.
    typedef struct packed {
        logic             report;
        logic [BIN_W-1:0] bin;
        logic [30:0]      lat;
    } cmd_t;

    function automatic logic [9:0] goal_permille(input logic [GOAL_W-1:0] g);
        logic [9:0] v;
        case (g)
            3'd0:    v = 10'd100;
            3'd1:    v = 10'd250;
            3'd2:    v = 10'd500;
            3'd3:    v = 10'd750;
            3'd4:    v = 10'd900;
            3'd5:    v = 10'd950;
            3'd6:    v = 10'd990;
            default: v = 10'd999;
        endcase
        return v;
    endfunction

endpackage

[sv/lhp_if.sv]
// ----------------------------------------------------------------------------
// lhp_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface lhp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/lhp_front.sv]
// ----------------------------------------------------------------------------
// lhp_front
// Accepts requests, drops negative latencies, computes the bucket, and
// pushes commands into a small queue.
// ----------------------------------------------------------------------------
module lhp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lhp_pkg::in_item_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output lhp_pkg::cmd_t     cmd_data
);
    import lhp_pkg::*;

    localparam int DEPTH = 4;
    localparam logic [31:0] CLAMP_LIM = 32'(BUCKET_US * (BINS - 1));

    cmd_t       q_reg [DEPTH];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;
    logic       push, pop;
    cmd_t       cmd;
    logic [31:0] quo;

    // Divide by ten by a reciprocal multiply; exact for 31-bit inputs.
    assign quo = 32'((64'(in_data.latency_us) * 64'hCCCCCCCD) >> 35);

    always_comb
    begin
        cmd.report = (in_data.func == FUNC_REPORT);
        cmd.lat    = in_data.latency_us[30:0];
        if (in_data.latency_us >= CLAMP_LIM)
            cmd.bin = BIN_W'(BINS - 1);
        else
            cmd.bin = quo[BIN_W-1:0];
    end

    assign in_ready  = (cnt_reg != 3'(DEPTH));
    assign push      = in_valid && in_ready &&
                       (in_data.func == FUNC_REPORT || !in_data.latency_us[31]);
    assign cmd_valid = (cnt_reg != 3'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_data  = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 2'd1;
            if (pop)  rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end
endmodule

[sv/lhp_div.sv]
// ----------------------------------------------------------------------------
// lhp_div
// Restoring divider: 64-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module lhp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);
    logic [63:0] q_reg;
    logic [31:0] r_reg;
    logic [31:0] d_reg;
    logic [6:0]  n_reg;
    logic [32:0] sh;
    logic        ge;

    assign sh       = {r_reg, q_reg[63]};
    assign ge       = (sh >= {1'b0, d_reg});
    assign busy     = (n_reg != 7'd0);
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_reg <= '0;
        else if (start)
            n_reg <= 7'd64;
        else if (busy)
            n_reg <= n_reg - 7'd1;
    end

    // The partial remainder always stays below the divisor, so 32 bits hold it.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy)
        begin
            r_reg <= 32'(ge ? sh - {1'b0, d_reg} : sh);
            q_reg <= {q_reg[62:0], ge};
        end
    end
endmodule

[sv/lhp_back.sv]
// ----------------------------------------------------------------------------
// lhp_back
// Histogram store and totals. Records do a read-modify-write; a report
// divides for the mean when there are samples, sweeps the buckets to find
// goals while clearing, then emits eight results.
// ----------------------------------------------------------------------------
module lhp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  lhp_pkg::cmd_t      cmd_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lhp_pkg::out_item_t out_data,
    output logic               clearing
);
    import lhp_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RMW   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_SWAIT = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [31:0] mem [BINS];
    logic [31:0] rd_data_reg;

    logic [2:0]       state_reg;
    logic [BIN_W-1:0] addr_reg;
    logic [BIN_W:0]   swp_reg;
    logic [31:0]      total_reg;
    logic [63:0]      sum_reg;
    logic [31:0]      least_reg;
    logic [31:0]      most_reg;
    logic [63:0]      cum_reg;
    logic [GOAL_W:0]  g_reg;
    logic [BIN_W-1:0] found_reg [GOALS];
    logic [30:0]      avg_reg;
    logic [GOAL_W-1:0] e_reg;
    logic             lat_upd_reg;
    logic [30:0]      lat_reg;

    logic        we;
    logic [BIN_W-1:0] waddr;
    logic [31:0] wdata;
    logic        div_start, div_busy;
    logic [63:0] div_q;
    logic [63:0] cum_next;
    logic [73:0] lhs;
    logic [73:0] rhs;
    logic        hit;

    lhp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (total_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign clearing  = (state_reg == S_INIT);
    assign cmd_ready = (state_reg == S_IDLE);
    assign div_start = (state_reg == S_IDLE) && cmd_valid && cmd_data.report &&
                       (total_reg != 32'd0);

    // cum*1000/total >= goal  <=>  cum*1000 >= goal*total
    assign cum_next = cum_reg + 64'(rd_data_reg);
    assign lhs = 74'(cum_next) * 74'd1000;
    assign rhs = 74'(goal_permille(g_reg[GOAL_W-1:0])) * 74'(total_reg);
    assign hit = !g_reg[GOAL_W] && (lhs >= rhs);

    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wdata = '0;
        case (state_reg)
            S_INIT:
            begin
                we = 1'b1;
            end
            S_RMW:
            begin
                we    = 1'b1;
                wdata = (rd_data_reg == 32'hFFFFFFFF) ? rd_data_reg : rd_data_reg + 32'd1;
            end
            S_SWAIT:
            begin
                // clear the bucket only when leaving it, so its count stays readable
                we = (total_reg == 32'd0) || !hit;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[(state_reg == S_IDLE) ? cmd_data.bin : addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            addr_reg    <= '0;
            swp_reg     <= '0;
            total_reg   <= '0;
            sum_reg     <= '0;
            least_reg   <= '1;
            most_reg    <= '0;
            cum_reg     <= '0;
            g_reg       <= '0;
            avg_reg     <= '0;
            e_reg       <= '0;
            lat_upd_reg <= 1'b0;
            lat_reg     <= '0;
            for (int i = 0; i < GOALS; i++)
                found_reg[i] <= '0;
        end
        else
        begin
            case (state_reg)
                S_INIT:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == BIN_W'(BINS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (!cmd_data.report)
                        begin
                            addr_reg  <= cmd_data.bin;
                            lat_reg   <= cmd_data.lat;
                            state_reg <= S_RMW;
                        end
                        else
                        begin
                            cum_reg <= '0;
                            g_reg   <= '0;
                            e_reg   <= '0;
                            avg_reg <= '0;
                            for (int i = 0; i < GOALS; i++)
                                found_reg[i] <= BIN_W'(BINS - 1);
                            addr_reg  <= '0;
                            swp_reg   <= '0;
                            state_reg <= (total_reg != 32'd0) ? S_DIV : S_SWAIT;
                            lat_upd_reg <= 1'b0;
                        end
                    end
                end
                S_RMW:
                begin
                    if (total_reg != 32'hFFFFFFFF)
                    begin
                        total_reg <= total_reg + 32'd1;
                        sum_reg   <= sum_reg + 64'(lat_reg);
                    end
                    if (most_reg < 32'(lat_reg))
                        most_reg <= 32'(lat_reg);
                    if (least_reg > 32'(lat_reg))
                        least_reg <= 32'(lat_reg);
                    state_reg <= S_IDLE;
                end
                S_DIV:
                begin
                    if (!div_busy && lat_upd_reg)
                    begin
                        avg_reg   <= div_q[30:0];
                        state_reg <= S_SWAIT;
                    end
                    lat_upd_reg <= 1'b1;
                end
                S_SWAIT:
                begin
                    // rd_data_reg holds bucket addr_reg; on a goal hit record it, else clear it and advance
                    if (total_reg != 32'd0)
                    begin
                        if (hit)
                        begin
                            found_reg[g_reg[GOAL_W-1:0]] <= addr_reg;
                            g_reg <= g_reg + 1'b1;
                        end
                        else
                        begin
                            cum_reg  <= cum_next;
                            addr_reg <= addr_reg + 1'b1;
                            swp_reg  <= swp_reg + 1'b1;
                            if (swp_reg == (BIN_W+1)'(BINS - 1))
                                state_reg <= S_EMIT;
                            else
                                state_reg <= S_SWEEP;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < GOALS; i++)
                            found_reg[i] <= '0;
                        addr_reg  <= addr_reg + 1'b1;
                        swp_reg   <= swp_reg + 1'b1;
                        state_reg <= (swp_reg == (BIN_W+1)'(BINS - 1)) ? S_EMIT : S_SWEEP;
                    end
                end
                S_SWEEP:
                begin
                    // wait here for the registered read of the next bucket
                    state_reg <= S_SWAIT;
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        e_reg <= e_reg + 1'b1;
                        if (e_reg == GOAL_W'(GOALS - 1))
                        begin
                            total_reg <= '0;
                            sum_reg   <= '0;
                            least_reg <= '1;
                            most_reg  <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        logic any;
        any = (total_reg != 32'd0);
        out_valid             = (state_reg == S_EMIT);
        out_data.goal_index   = e_reg;
        out_data.bucket_index = 12'(found_reg[e_reg]);
        out_data.sample_count = total_reg;
        out_data.avg_latency  = avg_reg;
        out_data.min_latency  = any ? least_reg : 32'd0;
        out_data.max_latency  = any ? most_reg[30:0] : 31'd0;
        out_data.last         = (e_reg == GOAL_W'(GOALS - 1));
    end
endmodule

[sv/latency_histogram_percentiles_top.sv]
// Record path: a record passes through the queue and a histogram read-modify-write
// (one read, one write); the histogram takes a new record only after that write.
// A report runs the mean divider when there are samples, then the bucket sweep
// (a read and a check per bucket, plus one step per goal found), then eight results.
// Reset: asynchronous, active low; afterwards a clearing pass over all BINS buckets
// zeroes the histogram while no request is taken.
// ----------------------------------------------------------------------------
// latency_histogram_percentiles_top
// Latency histogram with percentile reports.
// ----------------------------------------------------------------------------
module latency_histogram_percentiles_top (
    input logic clk,
    input logic rst_n,
    lhp_if.sink   in_ch,
    lhp_if.source out_ch
);
    import lhp_pkg::*;

    logic  cmd_valid, cmd_ready, clearing, front_ready;
    cmd_t  cmd_data;

    lhp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid && !clearing),
        .in_ready  (front_ready),
        .in_data   (in_ch.data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data)
    );

    assign in_ch.ready = front_ready && !clearing;

    lhp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data),
        .clearing  (clearing)
    );

    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && out_ch.data.last |=> !out_ch.valid)
        else $error("result after last");
    a_no_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ch.ready)
        else $error("request taken during clear");
    a_goal_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && !out_ch.data.last |=>
        out_ch.valid && out_ch.data.goal_index == $past(out_ch.data.goal_index) + 3'd1)
        else $error("goal order broken");
endmodule

[tb/latency_histogram_percentiles_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// latency_histogram_percentiles_top_tb
// Drives record and report requests into the latency monitor, keeps its own
// histogram, totals and extremes, and checks every percentile result in order.
// ----------------------------------------------------------------------------
module latency_histogram_percentiles_top_tb;
    import lhp_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;

    lhp_if #(.T(in_item_t))  in_ch ();
    lhp_if #(.T(out_item_t)) out_ch ();

    latency_histogram_percentiles_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow copy of the monitor's interval state.
    logic [31:0] hist_count [BINS];
    logic [31:0] seen_samples;
    logic [63:0] seen_total;
    logic [31:0] seen_least;
    logic [31:0] seen_most;

    in_item_t  pending_requests [$];
    out_item_t expected_results [$];
    int        fail_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    logic      hold_requests;
    longint    cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [9:0] goal_of(input int g);
        logic [9:0] v;
        case (g)
            0:       v = 10'd100;
            1:       v = 10'd250;
            2:       v = 10'd500;
            3:       v = 10'd750;
            4:       v = 10'd900;
            5:       v = 10'd950;
            6:       v = 10'd990;
            default: v = 10'd999;
        endcase
        return v;
    endfunction

    task automatic clear_interval_model();
        for (int i = 0; i < BINS; i++)
            hist_count[i] = '0;
        seen_samples = '0;
        seen_total   = '0;
        seen_least   = '1;
        seen_most    = '0;
    endtask

    task automatic add_sample(input logic [31:0] raw);
        int bin;
        if (raw[31])
            return;
        bin = raw / BUCKET_US;
        if (bin >= BINS)
            bin = BINS - 1;
        if (hist_count[bin] != 32'hFFFF_FFFF)
            hist_count[bin] = hist_count[bin] + 1;
        if (seen_samples != 32'hFFFF_FFFF)
        begin
            seen_samples = seen_samples + 1;
            seen_total   = seen_total + raw;
        end
        if (seen_most < raw)
            seen_most = raw;
        if (seen_least > raw)
            seen_least = raw;
    endtask

    task automatic predict_percentiles();
        logic [11:0] hit [GOALS];
        logic [63:0] cum;
        logic [63:0] avg;
        logic        any;
        out_item_t   r;
        int          g;
        any = seen_samples != 0;
        avg = '0;
        for (int k = 0; k < GOALS; k++)
            hit[k] = any ? 12'(BINS - 1) : 12'd0;
        if (any)
        begin
            cum = '0;
            g = 0;
            for (int i = 0; i < BINS && g < GOALS; i++)
            begin
                cum = cum + hist_count[i];
                while (g < GOALS && 64'(goal_of(g)) <= (cum * 1000) / seen_samples)
                begin
                    hit[g] = 12'(i);
                    g++;
                end
            end
            avg = seen_total / seen_samples;
        end
        for (int k = 0; k < GOALS; k++)
        begin
            r.goal_index   = 3'(k);
            r.bucket_index = hit[k];
            r.sample_count = any ? seen_samples : 32'd0;
            r.avg_latency  = avg[30:0];
            r.min_latency  = any ? seen_least : 32'd0;
            r.max_latency  = any ? seen_most[30:0] : 31'd0;
            r.last         = (k == GOALS - 1);
            expected_results = {expected_results, r};
        end
        clear_interval_model();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Driver: hold a request until accepted, idle at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.data.func == FUNC_REPORT)
                    predict_percentiles();
                else
                    add_sample(in_ch.data.latency_us);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_requests.size() != 0 && !hold_requests &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pending_requests.pop_front();
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random and compare each result with the oldest one due.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result at %0t", $time);
                    fail_count++;
                end
                else
                begin
                    out_item_t w;
                    out_item_t g;
                    w = expected_results.pop_front();
                    g = out_ch.data;
                    if (g.goal_index != w.goal_index)
                        report_mismatch("goal_index", g.goal_index, w.goal_index);
                    if (g.bucket_index != w.bucket_index)
                        report_mismatch("bucket_index", g.bucket_index, w.bucket_index);
                    if (g.sample_count != w.sample_count)
                        report_mismatch("sample_count", g.sample_count, w.sample_count);
                    if (g.avg_latency != w.avg_latency)
                        report_mismatch("avg_latency", g.avg_latency, w.avg_latency);
                    if (g.min_latency != w.min_latency)
                        report_mismatch("min_latency", g.min_latency, w.min_latency);
                    if (g.max_latency != w.max_latency)
                        report_mismatch("max_latency", g.max_latency, w.max_latency);
                    if (g.last != w.last)
                        report_mismatch("last", g.last, w.last);
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic in_item_t rec(input logic [31:0] lat);
        in_item_t it;
        it.func       = FUNC_RECORD;
        it.latency_us = lat;
        return it;
    endfunction

    function automatic in_item_t rpt();
        in_item_t it;
        it.func       = FUNC_REPORT;
        it.latency_us = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] random_latency();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(32'h7FFF_FFFF, 32'h7FFF_0000);
            2:       return $urandom_range(50000, 40000);
            3:       return $urandom_range(9);
            default: return $urandom_range(2000);
        endcase
    endfunction

    task automatic queue_request(input in_item_t it);
        pending_requests = {pending_requests, it};
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        fail_count     = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        clear_interval_model();
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty report, extremes, negatives, ties, clamp.
        queue_request(rpt());
        queue_request(rec(32'h8000_0000));
        queue_request(rec(32'hFFFF_FFFF));
        queue_request(rpt());
        queue_request(rec(32'd0));
        queue_request(rec(32'h7FFF_FFFF));
        queue_request(rec(32'd40950));
        queue_request(rec(32'd40959));
        queue_request(rec(32'd9));
        queue_request(rec(32'd10));
        queue_request(rec(32'h5555_5555));
        queue_request(rec(32'h2AAA_AAAA));
        queue_request(rpt());
        queue_request(rec(32'd123));
        queue_request(rpt());
        for (int i = 0; i < 5; i++)
            queue_request(rec(32'd777));
        queue_request(rec(32'hC000_0000));
        queue_request(rpt());
        wait_drained();

        // Random phases: free, sender idle, receiver stall, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 55 : (phase == 3) ? 20 : 0;
            recv_stall_pct = (phase == 2) ? 55 : (phase == 3) ? 20 : 0;
            for (int n = 0; n < 50; n++)
            begin
                if ($urandom_range(11) == 0)
                    queue_request(rpt());
                else
                    queue_request(rec(random_latency()));
            end
            queue_request(rpt());
            if (phase == 1)
            begin
                // Hold back new requests until all results are in.
                wait (pending_requests.size() < 25);
                @(posedge clk);
                hold_requests <= 1'b1;
                @(posedge clk);
                while (in_ch.valid || expected_results.size() != 0)
                    @(posedge clk);
                hold_requests <= 1'b0;
            end
            wait_drained();
        end

        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
